[rtl/aovs_pkg.sv]
// ----------------------------------------------------------------------------
// aovs_pkg: shared types and constant tables for the additive organ
// Opcodes, sequencer states, control bundle, partial table and the
// elaboration-time generators for the sine, gain and note step tables.
// ----------------------------------------------------------------------------
package aovs_pkg;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FLUSH,
    S_FINISH
  } seq_state_t;

  // control bundle from the sequencer to the datapath
  typedef struct packed {
    logic note_on;
    logic note_off;
    logic tick_start;
    logic issue;
    logic advance;
    logic out_load;
  } ctrl_t;

  localparam int RATIO_W  = 25;
  localparam int WEIGHT_W = 23;
  localparam int GAIN_W   = 15;
  localparam int SINE_W   = 16;
  localparam int ACC_W    = 64;
  localparam int TABLE_N  = 160;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [RATIO_W-1:0]  ratio;
    logic [WEIGHT_W-1:0] weight;
  } partial_t;

  typedef logic [GAIN_W-1:0] gain_rom_t [128];

  localparam logic [16:0] SEMITONE_Q16 [12] = '{
    17'd65536, 17'd69433, 17'd73562, 17'd77936, 17'd82570, 17'd87480,
    17'd92682, 17'd98193, 17'd104032, 17'd110218, 17'd116772, 17'd123715
  };

  localparam logic [63:0] TAYLOR_DIV [7] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
  };

  // ratio in Q16 from thousandths and multiplier, weight in Q24 from millionths
  function automatic partial_t pt(input logic [63:0] th, input logic [63:0] m,
                                  input logic [63:0] w);
    logic [63:0] r;
    logic [63:0] g;
    partial_t    p;
    r = (th * m * 64'd65536 + 64'd500) / 64'd1000;
    g = (w * 64'd16777216 + 64'd500000) / 64'd1000000;
    p.ratio  = r[RATIO_W-1:0];
    p.weight = g[WEIGHT_W-1:0];
    return p;
  endfunction

  // partial table: ratio and weight of each sine term
  function automatic partial_t partial_lookup(input logic [7:0] k);
    partial_t p;
    case (k)
      8'd0:   p = pt(1000, 2, 31600);   8'd1:   p = pt(3000, 2, 9440);
      8'd2:   p = pt(5000, 2, 1770);    8'd3:   p = pt(1000, 4, 31600);
      8'd4:   p = pt(3000, 4, 9440);    8'd5:   p = pt(5000, 4, 1770);
      8'd6:   p = pt(1000, 4, 45050);   8'd7:   p = pt(2000, 4, 108000);
      8'd8:   p = pt(3000, 4, 60900);   8'd9:   p = pt(4000, 4, 31900);
      8'd10:  p = pt(5000, 4, 18400);   8'd11:  p = pt(6000, 4, 39300);
      8'd12:  p = pt(7000, 4, 35000);   8'd13:  p = pt(8000, 4, 55500);
      8'd14:  p = pt(9000, 4, 33100);   8'd15:  p = pt(10000, 4, 41200);
      8'd16:  p = pt(11000, 4, 26300);  8'd17:  p = pt(12000, 4, 15100);
      8'd18:  p = pt(13000, 4, 12300);  8'd19:  p = pt(15000, 4, 2370);
      8'd20:  p = pt(16000, 4, 1390);   8'd21:  p = pt(1000, 8, 58000);
      8'd22:  p = pt(2000, 8, 22300);   8'd23:  p = pt(3000, 8, 329000);
      8'd24:  p = pt(4000, 8, 3710);    8'd25:  p = pt(5000, 8, 803);
      8'd26:  p = pt(6000, 8, 393);     8'd27:  p = pt(7000, 8, 1270);
      8'd28:  p = pt(8000, 8, 1050);    8'd29:  p = pt(9000, 8, 350);
      8'd30:  p = pt(10000, 8, 881);    8'd31:  p = pt(11227, 8, 489);
      8'd32:  p = pt(12000, 8, 323);    8'd33:  p = pt(1000, 2, 165500);
      8'd34:  p = pt(2000, 2, 34600);   8'd35:  p = pt(3000, 2, 51800);
      8'd36:  p = pt(4000, 2, 8030);    8'd37:  p = pt(5000, 2, 14100);
      8'd38:  p = pt(6000, 2, 2540);    8'd39:  p = pt(7000, 2, 1560);
      8'd40:  p = pt(8000, 2, 1490);    8'd41:  p = pt(10000, 2, 1020);
      8'd42:  p = pt(1000, 16, 21050);  8'd43:  p = pt(1331, 16, 58800);
      8'd44:  p = pt(2000, 16, 62300);  8'd45:  p = pt(2662, 16, 11700);
      8'd46:  p = pt(3000, 16, 2910);   8'd47:  p = pt(4000, 16, 4360);
      8'd48:  p = pt(5000, 16, 588);    8'd49:  p = pt(5325, 16, 4670);
      8'd50:  p = pt(6000, 16, 1840);   8'd51:  p = pt(6657, 16, 582);
      8'd52:  p = pt(7000, 16, 158);    8'd53:  p = pt(8000, 16, 3580);
      8'd54:  p = pt(9000, 16, 239);    8'd55:  p = pt(10000, 16, 616);
      8'd56:  p = pt(10651, 16, 1420);  8'd57:  p = pt(12000, 16, 543);
      8'd58:  p = pt(13314, 16, 518);   8'd59:  p = pt(14000, 16, 327);
      8'd60:  p = pt(14645, 16, 211);   8'd61:  p = pt(16256, 16, 803);
      8'd62:  p = pt(18000, 16, 254);   8'd63:  p = pt(18641, 16, 147);
      8'd64:  p = pt(21304, 16, 285);   8'd65:  p = pt(23967, 16, 114);
      8'd66:  p = pt(1000, 4, 110500);  8'd67:  p = pt(2000, 4, 74900);
      8'd68:  p = pt(3000, 4, 16500);   8'd69:  p = pt(4000, 4, 11300);
      8'd70:  p = pt(5000, 4, 2540);    8'd71:  p = pt(6000, 4, 3160);
      8'd72:  p = pt(7000, 4, 653);     8'd73:  p = pt(8000, 4, 350);
      8'd74:  p = pt(9000, 4, 478);     8'd75:  p = pt(10000, 4, 668);
      8'd76:  p = pt(11000, 4, 741);    8'd77:  p = pt(12000, 4, 575);
      8'd78:  p = pt(13000, 4, 412);    8'd79:  p = pt(14000, 4, 371);
      8'd80:  p = pt(15000, 4, 295);    8'd81:  p = pt(16281, 4, 237);
      8'd82:  p = pt(1000, 2, 83500);   8'd83:  p = pt(2000, 2, 78500);
      8'd84:  p = pt(3000, 2, 25100);   8'd85:  p = pt(4000, 2, 38400);
      8'd86:  p = pt(5000, 2, 5430);    8'd87:  p = pt(6000, 2, 9120);
      8'd88:  p = pt(7000, 2, 3010);    8'd89:  p = pt(8000, 2, 1710);
      8'd90:  p = pt(9000, 2, 1460);    8'd91:  p = pt(10000, 2, 1360);
      8'd92:  p = pt(11000, 2, 1090);   8'd93:  p = pt(18000, 2, 1080);
      8'd94:  p = pt(1000, 2, 17300);   8'd95:  p = pt(2000, 2, 37100);
      8'd96:  p = pt(3000, 2, 7940);    8'd97:  p = pt(4000, 2, 58200);
      8'd98:  p = pt(5000, 2, 10000);   8'd99:  p = pt(6000, 2, 29100);
      8'd100: p = pt(7000, 2, 25400);   8'd101: p = pt(8000, 2, 19900);
      8'd102: p = pt(9000, 2, 14400);   8'd103: p = pt(10000, 2, 14200);
      8'd104: p = pt(11000, 2, 10300);  8'd105: p = pt(12000, 2, 6230);
      8'd106: p = pt(13000, 2, 23400);  8'd107: p = pt(14000, 2, 12700);
      8'd108: p = pt(15000, 2, 11300);  8'd109: p = pt(16000, 2, 3120);
      8'd110: p = pt(17000, 2, 1360);   8'd111: p = pt(18000, 2, 2690);
      8'd112: p = pt(19000, 2, 2310);   8'd113: p = pt(20000, 2, 1210);
      8'd114: p = pt(21000, 2, 363);    8'd115: p = pt(1000, 1, 17300);
      8'd116: p = pt(2000, 1, 37100);   8'd117: p = pt(3000, 1, 7940);
      8'd118: p = pt(4000, 1, 58200);   8'd119: p = pt(5000, 1, 10000);
      8'd120: p = pt(6000, 1, 29100);   8'd121: p = pt(7000, 1, 25400);
      8'd122: p = pt(8000, 1, 19900);   8'd123: p = pt(9000, 1, 14400);
      8'd124: p = pt(10000, 1, 14200);  8'd125: p = pt(11000, 1, 10300);
      8'd126: p = pt(12000, 1, 6230);   8'd127: p = pt(13000, 1, 23400);
      8'd128: p = pt(14000, 1, 12700);  8'd129: p = pt(15000, 1, 11300);
      8'd130: p = pt(16000, 1, 3120);   8'd131: p = pt(17000, 1, 1360);
      8'd132: p = pt(18000, 1, 2690);   8'd133: p = pt(19000, 1, 2310);
      8'd134: p = pt(20000, 1, 1210);   8'd135: p = pt(21000, 1, 363);
      8'd136: p = pt(1000, 1, 41100);   8'd137: p = pt(2000, 1, 74900);
      8'd138: p = pt(3000, 1, 8410);    8'd139: p = pt(4000, 1, 2340);
      8'd140: p = pt(5000, 1, 1390);    8'd141: p = pt(6000, 1, 831);
      8'd142: p = pt(7000, 1, 1470);    8'd143: p = pt(8000, 1, 1900);
      8'd144: p = pt(9000, 1, 1160);    8'd145: p = pt(10000, 1, 530);
      8'd146: p = pt(11000, 1, 1460);   8'd147: p = pt(12000, 1, 363);
      8'd148: p = pt(13000, 1, 305);    8'd149: p = pt(1000, 1, 98500);
      8'd150: p = pt(2000, 1, 141000);  8'd151: p = pt(3000, 1, 113000);
      8'd152: p = pt(4385, 1, 131000);  8'd153: p = pt(5370, 1, 105000);
      8'd154: p = pt(6347, 1, 162000);  8'd155: p = pt(7327, 1, 118000);
      8'd156: p = pt(8308, 1, 52400);   8'd157: p = pt(9288, 1, 38900);
      8'd158: p = pt(10736, 1, 42600);  8'd159: p = pt(12000, 1, 19900);
      default: p = '0;
    endcase
    return p;
  endfunction

  // quarter-wave sine in Q15 from a Q30 Taylor series
  function automatic logic [15:0] quarter_sine(input logic [63:0] a, input int qbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    x    = (a * HALF_PI_Q30 + (64'd1 << (qbits - 1))) >> qbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int k = 0; k < 7; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k];
      if (k % 2 == 0) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 64'sd32767) sum = 64'sd32767;
    return sum[15:0];
  endfunction

  // equal-tempered phase step of a MIDI note
  function automatic logic [63:0] note_step(input logic [6:0] note, input int phase_bits);
    int          n;
    int          e;
    logic [63:0] k;
    logic [63:0] s;
    n = int'(note) + 3;
    e = phase_bits + n / 12 - 22;
    k = 64'd440 * 64'(SEMITONE_Q16[n % 12]);
    if (e >= 0) begin
      s = ((k << e) + 64'd22050) / 64'd44100;
    end else begin
      s = ((k + (64'd22050 << (-e))) >> (-e)) / 64'd44100;
    end
    return s;
  endfunction

  // largest Q14 gain g with g^4 * 127 <= velocity * 2^56
  function automatic gain_rom_t build_gain();
    gain_rom_t   t;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] sq;
    for (int v = 0; v < 128; v++) begin
      lo = 0;
      hi = 64'd16384;
      for (int it = 0; it < 16; it++) begin
        if (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          sq  = mid * mid;
          if (sq * sq * 64'd127 <= (64'(v) << 56)) lo = mid;
          else hi = mid - 64'd1;
        end
      end
      t[v] = lo[GAIN_W-1:0];
    end
    return t;
  endfunction

endpackage

[rtl/aovs_voice_bank.sv]
// ----------------------------------------------------------------------------
// aovs_voice_bank: per-voice phase, step, note and velocity registers
// Applies note events, advances phases after a tick, serves one read port.
// ----------------------------------------------------------------------------
module aovs_voice_bank #(
  parameter int VOICES     = 4,
  parameter int PHASE_BITS = 32,
  parameter int VW         = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  aovs_pkg::ctrl_t       ctrl,
  input  logic [6:0]            note_number,
  input  logic [6:0]            note_velocity,
  input  logic [VW-1:0]         rd_voice,
  output logic [PHASE_BITS-1:0] rd_phase,
  output logic [6:0]            rd_velocity
);
  import aovs_pkg::*;

  typedef logic [PHASE_BITS-1:0] step_rom_t [128];

  function automatic step_rom_t build_steps();
    step_rom_t   t;
    logic [63:0] s;
    for (int n = 0; n < 128; n++) begin
      s    = note_step(7'(n), PHASE_BITS);
      t[n] = s[PHASE_BITS-1:0];
    end
    return t;
  endfunction

  localparam step_rom_t STEP_ROM = build_steps();
  localparam logic [6:0] RESET_NOTE = 7'd45;

  logic [PHASE_BITS-1:0] voice_phase    [VOICES];
  logic [PHASE_BITS-1:0] phase_step     [VOICES];
  logic [6:0]            voice_note     [VOICES];
  logic [6:0]            voice_velocity [VOICES];
  logic [VW-1:0]         next_voice;
  logic [VW-1:0]         slot;

  // pick the round-robin slot, skipping it once if busy
  always_comb begin
    slot = next_voice;
    if (voice_note[next_voice] != 7'd0) begin
      slot = (next_voice == VW'(VOICES - 1)) ? '0 : next_voice + 1'b1;
    end
  end

  // hold voice state, apply note events and phase advance
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICES; i++) begin
        voice_phase[i]    <= '0;
        phase_step[i]     <= STEP_ROM[RESET_NOTE];
        voice_note[i]     <= '0;
        voice_velocity[i] <= '0;
      end
      next_voice <= '0;
    end else if (ctrl.note_on) begin
      voice_note[slot]     <= note_number;
      voice_velocity[slot] <= note_velocity;
      phase_step[slot]     <= STEP_ROM[note_number];
      next_voice <= (slot == VW'(VOICES - 1)) ? '0 : slot + 1'b1;
    end else if (ctrl.note_off) begin
      for (int i = 0; i < VOICES; i++) begin
        if (voice_note[i] == note_number) begin
          voice_note[i]     <= '0;
          voice_velocity[i] <= '0;
          phase_step[i]     <= '0;
        end
      end
    end else if (ctrl.advance) begin
      for (int i = 0; i < VOICES; i++) begin
        voice_phase[i] <= voice_phase[i] + phase_step[i];
      end
    end
  end

  assign rd_phase    = voice_phase[rd_voice];
  assign rd_velocity = voice_velocity[rd_voice];

endmodule

[rtl/aovs_partial_mac.sv]
// ----------------------------------------------------------------------------
// aovs_partial_mac: pipelined multiply-accumulate for one partial per cycle
// Phase times ratio, sine lookup, times weight, times gain, accumulate.
// ----------------------------------------------------------------------------
module aovs_partial_mac #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10,
  parameter int KW              = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  aovs_pkg::ctrl_t               ctrl,
  input  logic [PHASE_BITS-1:0]         phase,
  input  logic [6:0]                    velocity,
  input  logic [KW-1:0]                 partial_idx,
  output logic signed [aovs_pkg::ACC_W-1:0] acc,
  output logic                          busy
);
  import aovs_pkg::*;

  localparam int SINE_SIZE = 1 << SINE_TABLE_BITS;
  localparam int QBITS     = SINE_TABLE_BITS - 2;
  localparam int QUARTER   = 1 << QBITS;
  localparam int PROD_W    = PHASE_BITS + RATIO_W;

  typedef logic signed [SINE_W-1:0] sine_rom_t [SINE_SIZE];

  function automatic sine_rom_t build_sine();
    sine_rom_t   t;
    logic [15:0] v;
    int          quad;
    int          r;
    for (int i = 0; i < SINE_SIZE; i++) begin
      quad = i >> QBITS;
      r    = i & (QUARTER - 1);
      if (quad % 2 == 1) v = quarter_sine(64'(QUARTER - r), QBITS);
      else v = quarter_sine(64'(r), QBITS);
      t[i] = (quad >= 2) ? -$signed(v) : $signed(v);
    end
    return t;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();
  localparam gain_rom_t GAIN_ROM = build_gain();

  partial_t                    entry;
  logic [4:0]                  vld;
  logic [PHASE_BITS-1:0]       ph0;
  logic [RATIO_W-1:0]          ratio0;
  logic [WEIGHT_W-1:0]         w0, w1, w2;
  logic [GAIN_W-1:0]           g0, g1, g2, g3;
  logic [PROD_W-1:0]           prod_a;
  logic signed [SINE_W-1:0]    sine;
  logic signed [SINE_W+WEIGHT_W:0] prod_b;
  logic signed [SINE_W+WEIGHT_W+GAIN_W+1:0] prod_c;

  assign entry = partial_lookup(8'(partial_idx));

  // advance the valid chain
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[3:0], ctrl.issue};
  end

  // operand fetch, phase multiply, sine lookup, weight and gain multiplies
  always_ff @(posedge clk) begin
    ph0    <= phase;
    ratio0 <= entry.ratio;
    w0     <= entry.weight;
    g0     <= GAIN_ROM[velocity];
    prod_a <= PROD_W'(ph0) * PROD_W'(ratio0);
    w1     <= w0;
    g1     <= g0;
    sine   <= SINE_ROM[prod_a[PHASE_BITS+15 -: SINE_TABLE_BITS]];
    w2     <= w1;
    g2     <= g1;
    prod_b <= sine * $signed({1'b0, w2});
    g3     <= g2;
    prod_c <= prod_b * $signed({1'b0, g3});
  end

  // accumulate gained terms over all voices and partials
  always_ff @(posedge clk) begin
    if (rst || ctrl.tick_start) acc <= '0;
    else if (vld[4]) acc <= acc + ACC_W'(prod_c);
  end

  assign busy = |vld;

endmodule

[rtl/aovs_seq.sv]
// ----------------------------------------------------------------------------
// aovs_seq: sequencer for note events and the partial sweep of a tick
// Walks voices and partials, drains the pipeline, loads the output.
// ----------------------------------------------------------------------------
module aovs_seq #(
  parameter int VOICES   = 4,
  parameter int PARTIALS = 160,
  parameter int VW       = 2,
  parameter int KW       = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [1:0]      opcode,
  input  logic            out_valid,
  input  logic            out_stall,
  input  logic            pipe_busy,
  output logic            in_stall,
  output aovs_pkg::ctrl_t ctrl,
  output logic [VW-1:0]   voice_idx,
  output logic [KW-1:0]   partial_idx
);
  import aovs_pkg::*;

  seq_state_t state, state_next;
  logic       accept;
  logic       last_k;
  logic       last_v;

  // take requests only when idle and out of reset
  assign in_stall = rst || (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign last_k   = partial_idx == KW'(PARTIALS - 1);
  assign last_v   = voice_idx == VW'(VOICES - 1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept && opcode == OP_TICK) state_next = S_RUN;
      S_RUN:    if (last_k && last_v) state_next = S_FLUSH;
      S_FLUSH:  if (!pipe_busy) state_next = S_FINISH;
      S_FINISH: if (!(out_valid && out_stall)) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (opcode)
            OP_TICK:     ctrl.tick_start = 1'b1;
            OP_NOTE_ON:  ctrl.note_on = 1'b1;
            OP_NOTE_OFF: ctrl.note_off = 1'b1;
            default:     ctrl = '0;
          endcase
        end
      end
      S_RUN:    ctrl.issue = 1'b1;
      S_FLUSH:  ctrl = '0;
      S_FINISH: begin
        ctrl.out_load = !(out_valid && out_stall);
        ctrl.advance  = !(out_valid && out_stall);
      end
      default:  ctrl = '0;
    endcase
  end

  // hold state and sweep counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      voice_idx   <= '0;
      partial_idx <= '0;
    end else begin
      state <= state_next;
      if (ctrl.tick_start) begin
        voice_idx   <= '0;
        partial_idx <= '0;
      end else if (ctrl.issue) begin
        if (last_k) begin
          partial_idx <= '0;
          voice_idx   <= last_v ? '0 : voice_idx + 1'b1;
        end else begin
          partial_idx <= partial_idx + 1'b1;
        end
      end
    end
  end

  a_sweep_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> (voice_idx <= VW'(VOICES - 1)) && (partial_idx <= KW'(PARTIALS - 1)))
    else $error("sweep counter out of range");

  a_tick_runs: assert property (@(posedge clk) disable iff (rst)
    ctrl.tick_start |=> state == S_RUN && voice_idx == '0 && partial_idx == '0)
    else $error("tick did not start the sweep");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |-> !(out_valid && out_stall))
    else $error("output overwritten while stalled");

  a_no_issue_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !ctrl.issue && !ctrl.advance)
    else $error("datapath active while idle");

endmodule

[rtl/additive_organ_voice_synth_unit.sv]
// ----------------------------------------------------------------------------
// additive_organ_voice_synth_unit: four-voice additive organ oscillator bank
// Note events update the voice bank; a tick sums every partial of every voice.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  input    | in_valid / in_stall  | opcode, note_number, note_velocity, audio_in
//  output   | out_valid / out_stall| sample_out
//
//  Note on, note off and the unused opcode are applied at acceptance in idle.
//  A tick's result is loaded once the sweep has issued every term and the
//  pipeline has drained, and the next request is taken after that load: the
//  sweep issues one term per cycle into the five-stage multiply pipeline.
//  Reset is synchronous; it clears phases, notes, velocities, round-robin slot.
//  in_stall is high in reset, for the whole sweep and while the new result
//  waits for the previous one to be taken.
// ----------------------------------------------------------------------------
module additive_organ_voice_synth_unit #(
  parameter int VOICES          = 4,
  parameter int PHASE_BITS      = 32,
  parameter int PARTIALS        = 160,
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    opcode,
  input  logic [6:0]                    note_number,
  input  logic [6:0]                    note_velocity,
  input  logic signed [SAMPLE_BITS-1:0] audio_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out
);
  import aovs_pkg::*;

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int KW = (PARTIALS > 1) ? $clog2(PARTIALS) : 1;
  localparam int SH = 54 - SAMPLE_BITS;
  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) << (SH - 1);
  localparam logic signed [ACC_W-1:0] HI_LIM = (ACC_W'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam logic signed [ACC_W-1:0] LO_LIM = -(ACC_W'(1) << (SAMPLE_BITS - 1));

  ctrl_t                    ctrl;
  logic [VW-1:0]            voice_idx;
  logic [KW-1:0]            partial_idx;
  logic [PHASE_BITS-1:0]    rd_phase;
  logic [6:0]               rd_velocity;
  logic signed [ACC_W-1:0]  acc;
  logic                     pipe_busy;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic signed [ACC_W-1:0]  mixed;
  logic signed [SAMPLE_BITS-1:0] sat;

  aovs_seq #(.VOICES(VOICES), .PARTIALS(PARTIALS), .VW(VW), .KW(KW)) u_seq (
    .clk, .rst, .in_valid, .opcode, .out_valid, .out_stall, .pipe_busy,
    .in_stall, .ctrl, .voice_idx, .partial_idx
  );

  aovs_voice_bank #(.VOICES(VOICES), .PHASE_BITS(PHASE_BITS), .VW(VW)) u_bank (
    .clk, .rst, .ctrl, .note_number, .note_velocity,
    .rd_voice(voice_idx), .rd_phase, .rd_velocity
  );

  aovs_partial_mac #(
    .PHASE_BITS(PHASE_BITS), .SINE_TABLE_BITS(SINE_TABLE_BITS), .KW(KW)
  ) u_mac (
    .clk, .rst, .ctrl, .phase(rd_phase), .velocity(rd_velocity),
    .partial_idx, .acc, .busy(pipe_busy)
  );

  // hold the input sample of the request being mixed
  always_ff @(posedge clk) begin
    if (ctrl.tick_start) sample <= audio_in;
  end

  // round the voice sum, add the input, saturate
  always_comb begin
    mixed = ((acc + HALF) >>> SH) + ACC_W'(sample);
    if (mixed > HI_LIM) sat = HI_LIM[SAMPLE_BITS-1:0];
    else if (mixed < LO_LIM) sat = LO_LIM[SAMPLE_BITS-1:0];
    else sat = mixed[SAMPLE_BITS-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) sample_out <= sat;
  end

endmodule

[bench/additive_organ_voice_synth_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// additive_organ_voice_synth_unit_test: self-checking bench for the organ
// Drives note-on, note-off, unused and tick requests through the valid/stall
// input and predicts each tick's mixed sample with a bit-exact model of the
// voice bank, partial sweep, gain curve and saturation. Results are checked
// in order, under random idling on both sides, a long output hold-off and a
// full drain between phases.
// ----------------------------------------------------------------------------
module additive_organ_voice_synth_unit_test;
  import aovs_pkg::*;

  localparam int          NV         = 4;
  localparam int          NPART      = 160;
  localparam int          TICK_WAIT  = 700;
  localparam int          CYCLE_CAP  = 3000000;
  localparam logic [1:0]  OP_IGNORED = 2'd3;
  localparam longint      SAT_HI     = 64'sd8388607;
  localparam longint      SAT_LO     = -64'sd8388608;

  // partial table as (ratio in thousandths, multiplier, weight in millionths)
  localparam int unsigned PART_SPEC [NPART*3] = '{
    1000,2,31600, 3000,2,9440, 5000,2,1770,
    1000,4,31600, 3000,4,9440, 5000,4,1770,
    1000,4,45050, 2000,4,108000, 3000,4,60900, 4000,4,31900, 5000,4,18400,
    6000,4,39300, 7000,4,35000, 8000,4,55500, 9000,4,33100, 10000,4,41200,
    11000,4,26300, 12000,4,15100, 13000,4,12300, 15000,4,2370, 16000,4,1390,
    1000,8,58000, 2000,8,22300, 3000,8,329000, 4000,8,3710, 5000,8,803,
    6000,8,393, 7000,8,1270, 8000,8,1050, 9000,8,350, 10000,8,881,
    11227,8,489, 12000,8,323,
    1000,2,165500, 2000,2,34600, 3000,2,51800, 4000,2,8030, 5000,2,14100,
    6000,2,2540, 7000,2,1560, 8000,2,1490, 10000,2,1020,
    1000,16,21050, 1331,16,58800, 2000,16,62300, 2662,16,11700,
    3000,16,2910, 4000,16,4360, 5000,16,588, 5325,16,4670, 6000,16,1840,
    6657,16,582, 7000,16,158, 8000,16,3580, 9000,16,239, 10000,16,616,
    10651,16,1420, 12000,16,543, 13314,16,518, 14000,16,327,
    14645,16,211, 16256,16,803, 18000,16,254, 18641,16,147,
    21304,16,285, 23967,16,114,
    1000,4,110500, 2000,4,74900, 3000,4,16500, 4000,4,11300, 5000,4,2540,
    6000,4,3160, 7000,4,653, 8000,4,350, 9000,4,478, 10000,4,668,
    11000,4,741, 12000,4,575, 13000,4,412, 14000,4,371, 15000,4,295,
    16281,4,237,
    1000,2,83500, 2000,2,78500, 3000,2,25100, 4000,2,38400, 5000,2,5430,
    6000,2,9120, 7000,2,3010, 8000,2,1710, 9000,2,1460, 10000,2,1360,
    11000,2,1090, 18000,2,1080,
    1000,2,17300, 2000,2,37100, 3000,2,7940, 4000,2,58200, 5000,2,10000,
    6000,2,29100, 7000,2,25400, 8000,2,19900, 9000,2,14400, 10000,2,14200,
    11000,2,10300, 12000,2,6230, 13000,2,23400, 14000,2,12700, 15000,2,11300,
    16000,2,3120, 17000,2,1360, 18000,2,2690, 19000,2,2310, 20000,2,1210,
    21000,2,363,
    1000,1,17300, 2000,1,37100, 3000,1,7940, 4000,1,58200, 5000,1,10000,
    6000,1,29100, 7000,1,25400, 8000,1,19900, 9000,1,14400, 10000,1,14200,
    11000,1,10300, 12000,1,6230, 13000,1,23400, 14000,1,12700, 15000,1,11300,
    16000,1,3120, 17000,1,1360, 18000,1,2690, 19000,1,2310, 20000,1,1210,
    21000,1,363,
    1000,1,41100, 2000,1,74900, 3000,1,8410, 4000,1,2340, 5000,1,1390,
    6000,1,831, 7000,1,1470, 8000,1,1900, 9000,1,1160, 10000,1,530,
    11000,1,1460, 12000,1,363, 13000,1,305,
    1000,1,98500, 2000,1,141000, 3000,1,113000, 4385,1,131000,
    5370,1,105000, 6347,1,162000, 7327,1,118000, 8308,1,52400,
    9288,1,38900, 10736,1,42600, 12000,1,19900
  };

  localparam int unsigned SEMI_Q16 [12] = '{
    65536, 69433, 73562, 77936, 82570, 87480,
    92682, 98193, 104032, 110218, 116772, 123715
  };

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          opcode;
  logic [6:0]          note_number;
  logic [6:0]          note_velocity;
  logic signed [23:0]  audio_in;
  logic                out_valid;
  logic                out_stall;
  logic signed [23:0]  sample_out;

  // voice bank mirror
  logic [31:0]         osc_phase [NV];
  logic [31:0]         osc_step  [NV];
  logic [6:0]          held_note [NV];
  logic [6:0]          held_vel  [NV];
  int                  rr_slot;

  // lookup tables for the sample predictor
  longint              sine_q15   [1024];
  longint              gain_q14   [128];
  longint unsigned     ratio_q16  [NPART];
  longint              weight_q24 [NPART];

  logic signed [23:0]  pending_samples [$];
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  hold_cycles;
  int                  cycle_count;
  bit                  failed;

  additive_organ_voice_synth_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .note_number   (note_number),
    .note_velocity (note_velocity),
    .audio_in      (audio_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sample_out    (sample_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // quarter-wave sine in Q15 via a truncated Q30 Taylor series
  function automatic longint quarter_wave(input int unsigned a);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    x    = (longint'(a) * 64'd1686629713 + 64'd128) / 64'd256;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    acc = (acc + 16384) >>> 15;
    if (acc > 32767) acc = 32767;
    return acc;
  endfunction

  // equal-tempered phase step of a note, 32-bit phase
  function automatic logic [31:0] step_of_note(input logic [6:0] note);
    int              n;
    int              sh;
    longint unsigned k;
    longint unsigned s;
    n  = int'(note) + 3;
    sh = 32 + (n / 12 - 6) - 16;
    k  = 64'd440 * SEMI_Q16[n % 12];
    s  = ((k << sh) + 64'd22050) / 64'd44100;
    return s[31:0];
  endfunction

  // fill sine, gain and partial tables
  task automatic build_tables();
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned sq;
    int              quad;
    int              r;
    longint          v;
    for (int i = 0; i < 1024; i++) begin
      quad = i / 256;
      r    = i % 256;
      v    = (quad % 2 == 1) ? quarter_wave(256 - r) : quarter_wave(r);
      sine_q15[i] = (quad >= 2) ? -v : v;
    end
    for (int vel = 0; vel < 128; vel++) begin
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        sq  = mid * mid;
        if (sq * sq * 127 <= (longint'(vel) << 56)) lo = mid;
        else hi = mid - 1;
      end
      gain_q14[vel] = longint'(lo);
    end
    for (int p = 0; p < NPART; p++) begin
      ratio_q16[p]  = (longint'(PART_SPEC[3*p]) * PART_SPEC[3*p+1] * 65536 + 500) / 1000;
      weight_q24[p] = (longint'(PART_SPEC[3*p+2]) * 16777216 + 500000) / 1000000;
    end
  endtask

  task automatic clear_voice_bank();
    for (int i = 0; i < NV; i++) begin
      osc_phase[i] = '0;
      osc_step[i]  = step_of_note(7'd45);
      held_note[i] = '0;
      held_vel[i]  = '0;
    end
    rr_slot = 0;
  endtask

  // update the voice bank for one request, queue the sample a tick produces
  task automatic predict_request(input logic [1:0] op, input logic [6:0] note,
                                 input logic [6:0] vel, input logic signed [23:0] smp);
    int              slot;
    longint          mix;
    longint          voice_sum;
    longint unsigned frac;
    longint          y;
    logic [23:0]     y_bits;
    if (op == OP_NOTE_ON) begin
      slot = rr_slot;
      if (held_note[slot] != 0) slot = (slot + 1) % NV;
      held_note[slot] = note;
      held_vel[slot]  = vel;
      osc_step[slot]  = step_of_note(note);
      rr_slot = (slot + 1) % NV;
    end else if (op == OP_NOTE_OFF) begin
      for (int i = 0; i < NV; i++) begin
        if (held_note[i] == note) begin
          held_note[i] = '0;
          held_vel[i]  = '0;
          osc_step[i]  = '0;
        end
      end
    end else if (op == OP_TICK) begin
      mix = 0;
      for (int i = 0; i < NV; i++) begin
        voice_sum = 0;
        for (int p = 0; p < NPART; p++) begin
          frac = ((longint'(osc_phase[i]) * ratio_q16[p]) >> 16) & 64'hFFFF_FFFF;
          voice_sum += sine_q15[frac >> 22] * weight_q24[p];
        end
        mix += voice_sum * gain_q14[held_vel[i]];
      end
      y = ((mix + (64'sd1 <<< 29)) >>> 30) + longint'(smp);
      if (y > SAT_HI) y = SAT_HI;
      if (y < SAT_LO) y = SAT_LO;
      y_bits = y[23:0];
      pending_samples.push_back(y_bits);
      for (int i = 0; i < NV; i++) osc_phase[i] = osc_phase[i] + osc_step[i];
    end
  endtask

  // offer one request, hold it until accepted, then predict
  task automatic send_request(input logic [1:0] op, input logic [6:0] note,
                              input logic [6:0] vel, input logic signed [23:0] smp);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(4, 1);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      = 1'b1;
    opcode        = op;
    note_number   = note;
    note_velocity = vel;
    audio_in      = smp;
    do @(posedge clk); while (in_stall);
    predict_request(op, note, vel, smp);
  endtask

  // drop valid and wait until every queued sample has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [23:0] rand_audio();
    case ($urandom_range(5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'(int'($urandom_range(4095)) - 2048);
      default: return 24'($urandom);
    endcase
  endfunction

  // random request, biased toward note sequences that keep voices sounding
  task automatic random_request();
    int          pick;
    logic [6:0]  nt;
    pick = $urandom_range(99);
    if (pick < 35) begin
      send_request(OP_TICK, 7'($urandom), 7'($urandom), rand_audio());
    end else if (pick < 65) begin
      nt = ($urandom_range(9) == 0) ? 7'd0 : 7'($urandom_range(127, 1));
      send_request(OP_NOTE_ON, nt, 7'($urandom), 24'($urandom));
    end else if (pick < 90) begin
      nt = ($urandom_range(3) == 0) ? 7'($urandom) : held_note[$urandom_range(NV - 1)];
      send_request(OP_NOTE_OFF, nt, 7'($urandom), 24'($urandom));
    end else begin
      send_request(OP_IGNORED, 7'($urandom), 7'($urandom), 24'($urandom));
    end
  endtask

  // silent bank: samples pass through, extremes included
  task automatic test_silent_bank();
    send_request(OP_TICK, 7'd0, 7'd0, 24'sh7FFFFF);
    send_request(OP_TICK, 7'd127, 7'd127, 24'sh800000);
    send_request(OP_TICK, 7'd0, 7'd0, 24'sh000000);
    send_request(OP_TICK, 7'd0, 7'd0, -24'sd1);
  endtask

  // note on and off, busy slot skip and wrap, unused opcode, saturation
  task automatic test_note_events();
    send_request(OP_NOTE_ON, 7'd69, 7'd127, 24'sd0);
    send_request(OP_TICK, 7'd0, 7'd0, 24'sd0);
    send_request(OP_TICK, 7'd0, 7'd0, 24'sd0);
    send_request(OP_NOTE_ON, 7'd127, 7'd1, 24'sd0);
    send_request(OP_NOTE_ON, 7'd1, 7'd64, 24'sd0);
    send_request(OP_NOTE_ON, 7'd60, 7'd127, 24'sd0);
    // every slot busy: the next note-on skips once and overwrites
    send_request(OP_NOTE_ON, 7'd72, 7'd100, 24'sd0);
    send_request(OP_IGNORED, 7'd69, 7'd127, 24'sh7FFFFF);
    send_request(OP_TICK, 7'd0, 7'd0, 24'sh7FFFFF);
    send_request(OP_TICK, 7'd0, 7'd0, 24'sh800000);
    send_request(OP_NOTE_OFF, 7'd60, 7'd0, 24'sd0);
    send_request(OP_NOTE_OFF, 7'd72, 7'd0, 24'sd0);
    send_request(OP_TICK, 7'd0, 7'd0, 24'sd1000);
  endtask

  // note zero looks empty; note-off of zero freezes empty slots
  task automatic test_note_zero();
    send_request(OP_NOTE_ON, 7'd0, 7'd127, 24'sd0);
    send_request(OP_NOTE_ON, 7'd0, 7'd0, 24'sd0);
    send_request(OP_TICK, 7'd0, 7'd0, 24'sd0);
    send_request(OP_NOTE_OFF, 7'd0, 7'd0, 24'sd0);
    send_request(OP_TICK, 7'd0, 7'd0, 24'sd0);
    send_request(OP_TICK, 7'd0, 7'd0, 24'sd0);
  endtask

  task automatic test_random_traffic(input int count, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) random_request();
    drain_results();
  endtask

  // hold the output off while the sender keeps offering ticks
  task automatic test_output_holdoff();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_request(OP_NOTE_ON, 7'd48, 7'd90, 24'sd0);
    hold_cycles = 3000;
    repeat (5) send_request(OP_TICK, 7'd0, 7'd0, rand_audio());
    drain_results();
  endtask

  // reference clock count for the run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stall: long hold-off when requested, else random idling
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // compare each accepted sample with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected sample_out %0d", sample_out);
        failed = 1'b1;
      end else if (sample_out !== pending_samples[0]) begin
        $error("sample_out mismatch: expected %0d, actual %0d",
               pending_samples[0], sample_out);
        failed = 1'b1;
        void'(pending_samples.pop_front());
      end else begin
        void'(pending_samples.pop_front());
      end
    end
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    opcode        = OP_TICK;
    note_number   = '0;
    note_velocity = '0;
    audio_in      = '0;
    out_stall     = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles   = 0;
    cycle_count   = 0;
    failed        = 1'b0;
    build_tables();
    clear_voice_bank();
    repeat (5) @(negedge clk);
    rst = 1'b0;

    test_silent_bank();
    test_note_events();
    test_note_zero();
    drain_results();
    test_random_traffic(190, 12, 75);
    test_random_traffic(190, 75, 12);
    test_output_holdoff();
    test_random_traffic(170, 0, 0);

    repeat (TICK_WAIT) @(posedge clk);
    if (!failed && pending_samples.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
